[design/priority_queue_max_select_defines.svh]
// ----------------------------------------------------------------------------
// Priority queue assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_MAX_SELECT_DEFINES_SVH
`define PRIORITY_QUEUE_MAX_SELECT_DEFINES_SVH

// Property checked at every rising edge outside of reset.
`define PQMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked at every rising edge, reset included.
`define PQMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

[design/pqms_pkg.sv]
// ----------------------------------------------------------------------------
// Priority queue package
// Widths, codes, entry types and the ordering function of the queue cells.
// ----------------------------------------------------------------------------
package pqms_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountW       = 5;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] prio;
    logic signed [ValueW-1:0] value;
  } entry_t;

  // Contents of one cell as seen by its right-hand neighbor.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    slot_t slot;
    logic  ins_before;
  } link_t;

  // Broadcast command for the current request.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cell_ctrl_t;

  // Served-first order: higher priority, then higher value.
  function automatic logic entry_gt(entry_t a, entry_t b);
    entry_gt = (a.prio > b.prio) || ((a.prio == b.prio) && (a.value > b.value));
  endfunction

endpackage

[design/pqms_req_if.sv]
// ----------------------------------------------------------------------------
// Priority queue request channel
// Valid/ready channel carrying one enqueue or dequeue request.
// ----------------------------------------------------------------------------
interface pqms_req_if;
  logic                              valid;
  logic                              ready;
  logic [0:0]                        operation;
  logic signed [pqms_pkg::ValueW-1:0] item_value;
  logic signed [pqms_pkg::ValueW-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

[design/pqms_rsp_if.sv]
// ----------------------------------------------------------------------------
// Priority queue result channel
// Valid/ready channel carrying the status and head entry after a request.
// ----------------------------------------------------------------------------
interface pqms_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [pqms_pkg::ValueW-1:0] head_value;
  logic signed [pqms_pkg::ValueW-1:0] head_priority;
  logic                               queue_empty;
  logic [pqms_pkg::CountW-1:0]        entry_count;

  modport source (output valid, status, head_value, head_priority, queue_empty,
                  entry_count, input ready);
  modport sink   (input valid, status, head_value, head_priority, queue_empty,
                  entry_count, output ready);
endinterface

[design/pqms_cell.sv]
// ----------------------------------------------------------------------------
// Priority queue cell
// One slot of the sorted chain: inserts, shifts right on insert ahead of it,
// and shifts left on a dequeue.
// ----------------------------------------------------------------------------
`include "priority_queue_max_select_defines.svh"

module pqms_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pqms_pkg::cell_ctrl_t ctrl_i,
  input  pqms_pkg::link_t     left_i,
  input  pqms_pkg::slot_t     right_i,
  output pqms_pkg::link_t     link_o
);
  import pqms_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   ins_before;

  // The new entry belongs ahead of this slot. Equal keys go behind.
  assign ins_before = !valid_q || entry_gt(ctrl_i.entry, entry_q);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      valid_d = right_i.valid;
      entry_d = right_i.entry;
    end else if (ctrl_i.enq) begin
      if (left_i.ins_before) begin
        valid_d = left_i.slot.valid;
        entry_d = left_i.slot.entry;
      end else if (ins_before) begin
        valid_d = 1'b1;
        entry_d = ctrl_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.slot.valid  = valid_q;
  assign link_o.slot.entry  = entry_q;
  assign link_o.ins_before  = ins_before;

  // Occupied cells form a contiguous run from the head.
  `PQMS_ASSERT(a_cell_contiguous, right_i.valid |-> valid_q, "gap in queue chain")
  // A slot ahead of its neighbor never ranks below it.
  `PQMS_ASSERT(a_cell_sorted, (valid_q && right_i.valid) |-> !entry_gt(right_i.entry, entry_q),
               "queue chain out of order")
  // A request either inserts or removes, never both.
  `PQMS_ASSERT(a_cell_one_cmd, !(ctrl_i.enq && ctrl_i.deq), "insert and remove together")

endmodule

[design/priority_queue_max_select.sv]
// ----------------------------------------------------------------------------
// Priority queue with maximum select
// Bounded queue of value/priority pairs kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload
//  req_i   | in  | operation, item_value, item_priority
//  rsp_o   | out | status, head_value, head_priority, queue_empty, entry_count
//
//  Each request updates the cell chain; its result is valid
//  the cycle after acceptance, read straight from the head cell.
//  A new request is taken in the cycle the pending result is taken, so with
//  rsp_o.ready high one request per cycle flows; the result register sets it.
//  Reset clears the occupancy marks and the count at once; no clearing pass.
//  While a result stalls, req_i.ready is low and the chain holds still.
// ----------------------------------------------------------------------------
`include "priority_queue_max_select_defines.svh"

module priority_queue_max_select #(
  parameter int unsigned DEPTH = pqms_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pqms_req_if.sink   req_i,
  pqms_rsp_if.source rsp_o
);
  import pqms_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            accept;
  logic            is_deq;
  logic            full;
  logic            empty;
  logic [CntW-1:0] count_q, count_d;
  status_e         status_q, status_d;
  logic            out_valid_q;
  logic [CntW+CountW-1:0] count_ext;

  cell_ctrl_t ctrl;
  link_t      links [DEPTH];
  link_t      head_link;
  slot_t      tail_slot;

  assign accept = req_i.valid && req_i.ready;
  assign is_deq = (req_i.operation == OP_DEQUEUE);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  assign req_i.ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    ctrl.enq         = accept && !is_deq && !full;
    ctrl.deq         = accept && is_deq && !empty;
    ctrl.entry.prio  = req_i.item_priority;
    ctrl.entry.value = req_i.item_value;

    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      status_d = STATUS_OK;
      if (is_deq) begin
        if (empty) status_d = STATUS_UNDERFLOW;
        else       count_d  = count_q - CntW'(1);
      end else begin
        if (full)  status_d = STATUS_OVERFLOW;
        else       count_d  = count_q + CntW'(1);
      end
    end
  end

  // The head cell sees nothing ahead of it; the tail sees an empty slot.
  assign head_link.slot.valid = 1'b1;
  assign head_link.slot.entry = '0;
  assign head_link.ins_before = 1'b0;
  assign tail_slot.valid      = 1'b0;
  assign tail_slot.entry      = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left;
    slot_t right;
    if (i == 0) begin : g_first
      assign left = head_link;
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = tail_slot;
    end else begin : g_inner
      assign right = links[i+1].slot;
    end
    pqms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= accept || (out_valid_q && !rsp_o.ready);
    end
  end

  assign count_ext = (CntW + CountW)'(count_q);

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.head_value    = links[0].slot.valid ? links[0].slot.entry.value : '0;
  assign rsp_o.head_priority = links[0].slot.valid ? links[0].slot.entry.prio : '0;
  assign rsp_o.queue_empty   = empty;
  assign rsp_o.entry_count   = count_ext[CountW-1:0];

  `PQMS_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(DEPTH), "entry count above depth")
  `PQMS_ASSERT(a_count_matches_head, empty == !links[0].slot.valid,
               "entry count disagrees with head cell")
  `PQMS_ASSERT(a_overflow_when_full, (accept && !is_deq && full) |=>
               (status_q == STATUS_OVERFLOW && $stable(count_q)), "missed overflow")
  `PQMS_ASSERT(a_stall_holds_state, (out_valid_q && !rsp_o.ready) |=>
               ($stable(count_q) && $stable(links[0].slot)), "queue moved during stall")

endmodule
